// File: design/rafo_pkg.sv
// Package for the radial alpha falloff core: default widths, reset values and
// register indexes. Used by every module of the block.
package rafo_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ALPHA_W        = 8;
    localparam int Q_BITS         = 16;
    localparam int DIV_STAGES     = Q_BITS + 1;
    localparam int U_W            = Q_BITS + 1;
    localparam int SQUARINGS      = 3;
    localparam int RAD_SHIFT      = 31;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;
    localparam int TEX_SIZE_RESET = 256;

    localparam logic REG_TEX_SIZE = 1'b0;

endpackage

// File: design/rafo_sqrt_pipe.sv
// Pipelined integer square root of (d << 31), one root bit per stage.
// Depends on rafo_pkg; stage enables come from the top level.
module rafo_sqrt_pipe
    import rafo_pkg::*;
#(
    parameter int D_W = 2 * COORD_BITS_DEF + 3,
    parameter int RB  = (D_W + RAD_SHIFT) / 2
)
(
    input  logic                  clk,
    input  logic [RB-1:0]         en,
    input  logic [D_W-1:0]        d,
    output logic [RB-1:0]         root
);

    localparam int RAD_W = 2 * RB;
    localparam int REM_W = RB + 2;

    logic [REM_W-1:0] rem_reg  [RB];
    logic [RB-1:0]    root_reg [RB];
    logic [RAD_W-1:0] rad_reg  [RB];

    logic [REM_W-1:0] rem_in   [RB];
    logic [RB-1:0]    root_in  [RB];
    logic [RAD_W-1:0] rad_in   [RB];

    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign rad_in[0]  = RAD_W'({d, {RAD_SHIFT{1'b0}}});

    genvar k;
    generate
        for (k = 0; k < RB; k++)
        begin : g_stage
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;
            logic             ge;

            if (k > 0)
            begin : g_link
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
                assign rad_in[k]  = rad_reg[k-1];
            end

            assign rem_sh = {rem_in[k][RB-1:0], rad_in[k][RAD_W-1 -: 2]};
            assign trial  = {root_in[k], 2'b01};
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_in[k][RB-2:0], ge};
                    rad_reg[k]  <= {rad_in[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[RB-1];

endmodule

// File: design/rafo_div_pipe.sv
// Pipelined restoring divider: quotient bits 16..0 of root / size, one per stage.
// Depends on rafo_pkg; bit 16 set means the ratio reached one.
module rafo_div_pipe
    import rafo_pkg::*;
#(
    parameter int RB = COORD_BITS_DEF + 17,
    parameter int SW = COORD_BITS_DEF + 1
)
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [RB-1:0]         root,
    input  logic [SW-1:0]         size,
    output logic [U_W-1:0]        quot
);

    logic [RB-1:0]  rem_reg [DIV_STAGES];
    logic [U_W-1:0] q_reg   [DIV_STAGES];
    logic [RB-1:0]  rem_in  [DIV_STAGES];
    logic [U_W-1:0] q_in    [DIV_STAGES];

    assign rem_in[0] = root;
    assign q_in[0]   = '0;

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [RB-1:0] dsh;
            logic          ge;

            if (k > 0)
            begin : g_link
                assign rem_in[k] = rem_reg[k-1];
                assign q_in[k]   = q_reg[k-1];
            end

            assign dsh = RB'(size) << (DIV_STAGES - 1 - k);
            assign ge  = (rem_in[k] >= dsh);

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= ge ? (rem_in[k] - dsh) : rem_in[k];
                    q_reg[k]   <= {q_in[k][U_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quot = q_reg[DIV_STAGES-1];

endmodule

// File: design/radial_alpha_falloff_core.sv
// Radial alpha falloff core: alpha = (1 - r)^8 * 255 per pixel of a square sprite.
// Throughput: one beat per cycle; each stage holds only while the one after it is full.
// Depth is set by the bit-per-stage square root and divider pipelines.
// Reset: asynchronous, active low; clears all valid bits and sets tex_size to 256.
// Depends on rafo_pkg, rafo_sqrt_pipe and rafo_div_pipe.
module radial_alpha_falloff_core
    import rafo_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TDATA_W    = ((2 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    // [COORD_BITS-1:0] col, [2*COORD_BITS-1:COORD_BITS] row
    input  logic [TDATA_W-1:0]  s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] alpha
    output logic [ALPHA_W-1:0]  m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int SW      = COORD_BITS + 1;
    localparam int SQ_W    = 2 * SW;
    localparam int D_W     = SQ_W + 1;
    localparam int RB      = (D_W + RAD_SHIFT) / 2;
    localparam int ST_DIFF = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_ROOT = 3;
    localparam int ST_DIV  = ST_ROOT + RB;
    localparam int ST_U    = ST_DIV + DIV_STAGES;
    localparam int ST_P0   = ST_U + 1;
    localparam int ST_OUT  = ST_P0 + SQUARINGS;
    localparam int NSTAGE  = ST_OUT + 1;

    logic [SW-1:0]   tex_size_reg;
    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] en;

    logic [SW-1:0]   dx_reg, dy_reg;
    logic [SQ_W-1:0] sx_reg, sy_reg;
    logic [D_W-1:0]  d_reg;
    logic [RB-1:0]   root;
    logic [U_W-1:0]  quot;
    logic [U_W-1:0]  u_reg [SQUARINGS+1];
    logic [ALPHA_W-1:0] alpha_reg;

    logic [COORD_BITS-1:0] col, row;
    logic [SW-1:0]   col2, row2;

    // configuration
    assign pready = 1'b1;
    assign prdata = APB_DW'(tex_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tex_size_reg <= SW'(TEX_SIZE_RESET);
        else if (psel && penable && pwrite && (paddr[2] == REG_TEX_SIZE))
            tex_size_reg <= pwdata[SW-1:0];
    end

    // stage enables: advance a stage when it is empty or its successor advances
    assign en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_tready;
    genvar i;
    generate
        for (i = 0; i < NSTAGE - 1; i++)
        begin : g_en
            assign en[i] = !v_reg[i] || en[i+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTAGE-1];
    assign m_tdata  = alpha_reg;

    // front end: distances from centre, squares, sum
    assign col  = s_tdata[COORD_BITS-1:0];
    assign row  = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign col2 = {col, 1'b0};
    assign row2 = {row, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            dx_reg <= (col2 >= tex_size_reg) ? (col2 - tex_size_reg) : (tex_size_reg - col2);
            dy_reg <= (row2 >= tex_size_reg) ? (row2 - tex_size_reg) : (tex_size_reg - row2);
        end
        if (en[ST_SQ])
        begin
            sx_reg <= dx_reg * dx_reg;
            sy_reg <= dy_reg * dy_reg;
        end
        if (en[ST_SUM])
            d_reg <= D_W'(sx_reg) + D_W'(sy_reg);
    end

    rafo_sqrt_pipe #(
        .D_W (D_W),
        .RB  (RB)
    ) u_sqrt (
        .clk  (clk),
        .en   (en[ST_ROOT +: RB]),
        .d    (d_reg),
        .root (root)
    );

    rafo_div_pipe #(
        .RB (RB),
        .SW (SW)
    ) u_div (
        .clk  (clk),
        .en   (en[ST_DIV +: DIV_STAGES]),
        .root (root),
        .size (tex_size_reg),
        .quot (quot)
    );

    // back end: 1 - r, three squarings, scale to a byte
    always_ff @(posedge clk)
    begin
        if (en[ST_U])
            u_reg[0] <= quot[U_W-1] ? '0 : ((U_W'(1) << Q_BITS) - {1'b0, quot[Q_BITS-1:0]});
    end

    generate
        for (i = 0; i < SQUARINGS; i++)
        begin : g_square
            logic [2*U_W-1:0] prod;
            assign prod = u_reg[i] * u_reg[i];
            always_ff @(posedge clk)
            begin
                if (en[ST_P0 + i])
                    u_reg[i+1] <= prod[Q_BITS +: U_W];
            end
        end
    endgenerate

    logic [U_W+ALPHA_W-1:0] scaled;
    assign scaled = {u_reg[SQUARINGS], {ALPHA_W{1'b0}}} - (U_W + ALPHA_W)'(u_reg[SQUARINGS]);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            alpha_reg <= scaled[Q_BITS +: ALPHA_W];
    end

endmodule

// File: design/rafo_checker.sv
// Port-level checks for radial_alpha_falloff_core, attached by a bind.
// Depends on rafo_pkg for the output width.
module rafo_checker
    import rafo_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [ALPHA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_flow_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

endmodule

bind radial_alpha_falloff_core rafo_checker u_rafo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
